FILE: rtl/sigpd_pkg.sv
// Shared types and constants for the signal pending/delivery block.
// No dependencies; used by every module under rtl/.
package sigpd_pkg;

   localparam int NUM_SIGNALS = 32;
   localparam int SIG_W       = 5;
   localparam int MASK_W      = 32;
   localparam int EXIT_W      = 8;

   localparam logic [63:0] SIG_ALL_WIDE = (64'd1 << NUM_SIGNALS) - 64'd1;
   // signals 1 .. NUM_SIGNALS-1 may be posted; signal 0 never
   localparam logic [MASK_W-1:0] SIG_VALID_MASK = SIG_ALL_WIDE[MASK_W-1:0] & ~32'd1;

   localparam logic [SIG_W-1:0] SIG_KILL = 5'd9;
   localparam logic [SIG_W-1:0] SIG_CONT = 5'd18;
   localparam logic [SIG_W-1:0] SIG_STOP = 5'd19;
   localparam logic [2:0]       EXIT_BASE_TOP = 3'b100; // 128 + signal, signal < 32

   // default-terminate set: 1,2,3,4,6,8,11,13,15
   localparam logic [MASK_W-1:0] TERM_SET =
      (32'd1 << 1) | (32'd1 << 2) | (32'd1 << 3) | (32'd1 << 4) | (32'd1 << 6) |
      (32'd1 << 8) | (32'd1 << 11) | (32'd1 << 13) | (32'd1 << 15);

   typedef enum logic [1:0] {
      CMD_SEND  = 2'd0,
      CMD_CHECK = 2'd1,
      CMD_SET   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_RUNNING = 3'd0,
      ST_READY   = 3'd1,
      ST_BLOCKED = 3'd2,
      ST_STOPPED = 3'd3,
      ST_ZOMBIE  = 3'd4
   } run_state_type;

   typedef struct packed {
      logic [MASK_W-1:0] pending;
      run_state_type     run_state;
      logic [EXIT_W-1:0] term_code;
   } task_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [SIG_W-1:0] signal_number;
      logic [2:0]       new_state;
   } req_type;

   // register map: word index from paddr[2]
   localparam logic REG_HANDLED_MASK = 1'b0;

endpackage

FILE: rtl/sigpd_csr.sv
// APB-style register file holding the handled-signal mask.
// Depends on sigpd_pkg.
module sigpd_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [sigpd_pkg::MASK_W-1:0] handled_mask
);

   logic [sigpd_pkg::MASK_W-1:0] handled_ff;
   logic                         wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == sigpd_pkg::REG_HANDLED_MASK);

   always_ff @(posedge clock) begin
      if (reset) begin
         handled_ff <= '0;
      end else if (wr_hit) begin
         handled_ff <= csr_pwdata;
      end
   end

   assign csr_prdata   = (csr_paddr[2] == sigpd_pkg::REG_HANDLED_MASK) ? handled_ff : 32'd0;
   assign handled_mask = handled_ff;

endmodule

FILE: rtl/sigpd_step.sv
// Next-state logic for one command: send, pending scan, set state.
// Depends on sigpd_pkg. Purely combinational.
module sigpd_step (
   input  sigpd_pkg::req_type             req,
   input  sigpd_pkg::task_type            cur,
   input  logic [sigpd_pkg::MASK_W-1:0]   handled_mask,
   output sigpd_pkg::task_type            nxt,
   output logic                           status
);

   logic [sigpd_pkg::MASK_W-1:0] halt_mask;
   logic [sigpd_pkg::MASK_W-1:0] hits;
   logic [sigpd_pkg::MASK_W-1:0] iso;
   logic [sigpd_pkg::MASK_W-1:0] clr;
   logic [sigpd_pkg::SIG_W-1:0]  idx;
   logic                         cont_seen;
   logic                         bad_sig;
   sigpd_pkg::task_type          scan;

   // stop points of the scan: kill, stop, unhandled default-terminate
   assign halt_mask = (32'd1 << sigpd_pkg::SIG_KILL) | (32'd1 << sigpd_pkg::SIG_STOP) |
                      (sigpd_pkg::TERM_SET & ~handled_mask);
   assign hits = cur.pending & sigpd_pkg::SIG_VALID_MASK & halt_mask;
   assign iso  = hits & (~hits + 32'd1);
   // everything at or below the halt is visited and cleared
   assign clr  = (hits == '0) ? '1 : (iso | (iso - 32'd1));
   assign cont_seen = cur.pending[sigpd_pkg::SIG_CONT] & clr[sigpd_pkg::SIG_CONT];

   always_comb begin
      idx = '0;
      for (int i = 0; i < sigpd_pkg::MASK_W; i++) begin
         if (iso[i]) begin
            idx = idx | sigpd_pkg::SIG_W'(i);
         end
      end
   end

   always_comb begin
      scan         = cur;
      scan.pending = cur.pending & ~clr;
      if (iso[sigpd_pkg::SIG_STOP]) begin
         scan.run_state = sigpd_pkg::ST_STOPPED;
      end else if (hits != '0) begin
         scan.run_state = sigpd_pkg::ST_ZOMBIE;
         scan.term_code = {sigpd_pkg::EXIT_BASE_TOP, idx};
      end else if (cont_seen && cur.run_state == sigpd_pkg::ST_STOPPED) begin
         scan.run_state = sigpd_pkg::ST_READY;
      end
   end

   assign bad_sig = (req.signal_number == '0) ||
                    ({1'b0, req.signal_number} >= (sigpd_pkg::SIG_W + 1)'(sigpd_pkg::NUM_SIGNALS));

   always_comb begin
      nxt    = cur;
      status = 1'b0;
      case (req.cmd)
         sigpd_pkg::CMD_SEND: begin
            if (bad_sig) begin
               status = 1'b1;
            end else begin
               nxt.pending = cur.pending | (32'd1 << req.signal_number);
               if (cur.run_state == sigpd_pkg::ST_BLOCKED) begin
                  nxt.run_state = sigpd_pkg::ST_READY;
               end
            end
         end
         sigpd_pkg::CMD_CHECK: begin
            nxt = scan;
         end
         sigpd_pkg::CMD_SET: begin
            if (req.new_state <= 3'(sigpd_pkg::ST_ZOMBIE)) begin
               nxt.run_state = sigpd_pkg::run_state_type'(req.new_state);
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

FILE: rtl/signal_pending_delivery_top.sv
// Top level of the signal pending/delivery block: stream ports, task state
// registers and the result register. Depends on sigpd_pkg, sigpd_csr, sigpd_step.
//
// One task's pending-signal mask, run state and exit code. Commands arrive as
// items on req_* and each produces exactly one result item on rsp_* carrying the
// status and the task state after the command. The block takes one item per
// clock cycle unless the result stream stalls; an accepted item passes through
// the input register, then the result register. The rate is set by the pending
// scan, a combinational lowest-halt search and prefix-clear over the 32 pending
// bits that sits between the input register and the task state.
// Reset clears the task to running, nothing pending, exit code 0, and the
// handled mask to 0; there is no start-up sweep. Write handled_mask (byte
// address 0) only while no item is in flight.
module signal_pending_delivery_top (
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] cmd, [6:2] signal_number, [9:7] new_state, rest 0
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [0] status, [3:1] run_state, [11:4] exit_value,
                                    // [43:12] pending_out, rest 0
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [sigpd_pkg::MASK_W-1:0] handled_mask;

   // input register
   logic                in_vld_ff;
   sigpd_pkg::req_type  req_ff;

   // task state
   sigpd_pkg::task_type task_ff;
   sigpd_pkg::task_type task_in;
   logic                status_in;

   // result register
   logic                out_vld_ff;
   logic                status_ff;
   sigpd_pkg::task_type out_ff;

   logic                adv;   // item in input register moves to the result register

   sigpd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .handled_mask (handled_mask)
   );

   sigpd_step u_step (
      .req          (req_ff),
      .cur          (task_ff),
      .handled_mask (handled_mask),
      .nxt          (task_in),
      .status       (status_in)
   );

   // result slot frees up when it is empty or being taken this cycle
   assign adv        = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   // payload: no reset needed; struct holds cmd in its top bits
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff <= {req_tdata[1:0], req_tdata[6:2], req_tdata[9:7]};
      end
   end

   // task state advances exactly once per item, in order
   always_ff @(posedge clock) begin
      if (reset) begin
         task_ff.pending   <= '0;
         task_ff.run_state <= sigpd_pkg::ST_RUNNING;
         task_ff.term_code <= '0;
      end else if (adv) begin
         task_ff <= task_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff <= status_in;
         out_ff    <= task_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0, out_ff.pending, out_ff.term_code, out_ff.run_state, status_ff};

`ifndef SYNTHESIS
   // signal 0 can never become pending
   a_no_sig0: assert property (@(posedge clock) disable iff (reset)
      !task_ff.pending[0])
      else $error("signal 0 pending");

   // task state only moves when an item is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(task_ff))
      else $error("task state changed without an item");

   // exit code only changes on a kill
   a_exit_on_kill: assert property (@(posedge clock) disable iff (reset)
      (adv && task_in.term_code != task_ff.term_code) |->
         task_in.run_state == sigpd_pkg::ST_ZOMBIE)
      else $error("exit code changed without a kill");

   // a scan only clears pending bits
   a_check_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && req_ff.cmd == sigpd_pkg::CMD_CHECK) |-> (task_in.pending & ~task_ff.pending) == '0)
      else $error("scan set a pending bit");

   // every processed item shows up as a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_tvalid)
      else $error("processed item produced no result");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for signal_pending_delivery_top: command items in,
// one task-state result item out per command. Depends on sigpd_pkg and the RTL.
module tb;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 8;
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;
   localparam logic [2:0]  HANDLED_MASK_ADDR = {sigpd_pkg::REG_HANDLED_MASK, 2'b00};

   // default actions, spelled out independently
   localparam logic [4:0]  KILL_SIGNAL  = 5'd9;
   localparam logic [4:0]  CONT_SIGNAL  = 5'd18;
   localparam logic [4:0]  STOP_SIGNAL  = 5'd19;
   localparam int          EXIT_OFFSET  = 128;
   localparam logic [31:0] TERMINATING  = 32'h0000_A95E; // 1,2,3,4,6,8,11,13,15

   typedef struct packed {
      logic                     status;
      sigpd_pkg::run_state_type run_state;
      logic [7:0]               exit_value;
      logic [31:0]              pending;
   } task_outcome_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [1:0] cmd, [6:2] signal_number, [9:7] new_state
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [0] status, [3:1] run_state, [11:4] exit_value,
                             // [43:12] pending_out
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow copy of the task held by the block
   logic [31:0]              shadow_pending;
   sigpd_pkg::run_state_type shadow_state;
   logic [7:0]               shadow_exit;
   logic [31:0]              shadow_handled;

   task_outcome_type pending_outcomes[$];
   int               mismatch_count  = 0;
   int               cycle_count     = 0;
   int               hold_off_cycles = 0;   // long receiver hold-off request
   bit               quiet           = 1'b0; // no idling on either side

   signal_pending_delivery_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** signal_pending_delivery_top: FAILED **");
         $finish;
      end
   end

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Applies one command to the shadow task and returns the result it should give.
   function automatic task_outcome_type apply_command(logic [1:0] cmd, logic [4:0] sig,
                                                      logic [2:0] nst);
      task_outcome_type outcome;
      logic             halted;
      outcome.status = 1'b0;
      halted = 1'b0;
      case (cmd)
         sigpd_pkg::CMD_SEND: begin
            if (sig == 0 || sig >= sigpd_pkg::NUM_SIGNALS) begin
               outcome.status = 1'b1;
            end else begin
               shadow_pending[sig] = 1'b1;
               if (shadow_state == sigpd_pkg::ST_BLOCKED)
                  shadow_state = sigpd_pkg::ST_READY;
            end
         end
         sigpd_pkg::CMD_CHECK: begin
            // ascending walk; each visited bit is cleared, kill/stop/unhandled terminating halt it
            for (int n = 1; n < sigpd_pkg::NUM_SIGNALS; n++) begin
               if (!halted && shadow_pending[n]) begin
                  shadow_pending[n] = 1'b0;
                  if (n == KILL_SIGNAL) begin
                     shadow_state = sigpd_pkg::ST_ZOMBIE;
                     shadow_exit  = 8'(EXIT_OFFSET + n);
                     halted = 1'b1;
                  end else if (n == STOP_SIGNAL) begin
                     shadow_state = sigpd_pkg::ST_STOPPED;
                     halted = 1'b1;
                  end else if (n == CONT_SIGNAL) begin
                     if (shadow_state == sigpd_pkg::ST_STOPPED)
                        shadow_state = sigpd_pkg::ST_READY;
                  end else if (!shadow_handled[n] && TERMINATING[n]) begin
                     shadow_state = sigpd_pkg::ST_ZOMBIE;
                     shadow_exit  = 8'(EXIT_OFFSET + n);
                     halted = 1'b1;
                  end
               end
            end
         end
         sigpd_pkg::CMD_SET: begin
            if (nst <= sigpd_pkg::ST_ZOMBIE)
               shadow_state = sigpd_pkg::run_state_type'(nst);
         end
         default: ;
      endcase
      outcome.run_state  = shadow_state;
      outcome.exit_value = shadow_exit;
      outcome.pending    = shadow_pending;
      return outcome;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Offers one item and holds it until accepted; the prediction is made at the
   // accepting edge, then a random gap follows with junk on the data lines.
   task automatic send_item(logic [1:0] cmd, logic [4:0] sig, logic [2:0] nst);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, nst, sig, cmd};
      do
         @(posedge clock);
      while (!req_tready);
      pending_outcomes.push_back(apply_command(cmd, sig, nst));
      gap = random_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= {6'd0, 10'($urandom)};
      end
   endtask

   // Lowers valid, waits for every outstanding result, then lets the pipe settle.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_handled_mask(logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= HANDLED_MASK_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      shadow_handled = value;
      // read it back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== value)
         report_mismatch("handled_mask readback", 48'(csr_prdata), 48'(value));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Receiver: ready changes at the falling edge; long hold-off has priority.
   always @(negedge clock) begin : drive_ready
      int stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 9) < 3) begin
         rsp_tready <= 1'b0;
         stall_left = random_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Each accepted result against the oldest expectation, field by field.
   always @(posedge clock) begin : check_results
      task_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_tdata, '0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[0] !== want.status)
               report_mismatch("status", 48'(rsp_tdata[0]), 48'(want.status));
            if (rsp_tdata[3:1] !== want.run_state)
               report_mismatch("run_state", 48'(rsp_tdata[3:1]), 48'(want.run_state));
            if (rsp_tdata[11:4] !== want.exit_value)
               report_mismatch("exit_value", 48'(rsp_tdata[11:4]), 48'(want.exit_value));
            if (rsp_tdata[43:12] !== want.pending)
               report_mismatch("pending_out", 48'(rsp_tdata[43:12]), 48'(want.pending));
            if (rsp_tdata[47:44] !== 4'd0)
               report_mismatch("tdata padding", 48'(rsp_tdata[47:44]), '0);
         end
      end
   end

   // Bad numbers, unused command, bad state, wakeup, continue, stop and kills.
   task automatic test_default_actions();
      write_handled_mask(32'd0);
      send_item(sigpd_pkg::CMD_SEND, 5'd0, 3'd0);          // signal 0 rejected
      send_item(sigpd_pkg::CMD_SEND, 5'd31, 3'd7);         // highest legal signal
      send_item(sigpd_pkg::CMD_CHECK, 5'd31, 3'd7);        // 31 has no default action
      send_item(sigpd_pkg::CMD_CHECK, 5'd0, 3'd0);         // nothing pending
      send_item(sigpd_pkg::CMD_SET, 5'd0, 3'd7);           // out-of-range state ignored
      send_item(CMD_UNUSED, 5'd31, 3'd7);
      send_item(sigpd_pkg::CMD_SET, 5'd0, sigpd_pkg::ST_BLOCKED);
      send_item(sigpd_pkg::CMD_SEND, 5'd5, 3'd0);          // wakes blocked task
      send_item(sigpd_pkg::CMD_SET, 5'd0, sigpd_pkg::ST_STOPPED);
      send_item(sigpd_pkg::CMD_SEND, CONT_SIGNAL, 3'd0);
      send_item(sigpd_pkg::CMD_SEND, 5'd25, 3'd0);
      send_item(sigpd_pkg::CMD_SEND, STOP_SIGNAL, 3'd0);
      send_item(sigpd_pkg::CMD_CHECK, 5'd0, 3'd0);         // continue, then stop halts
      send_item(sigpd_pkg::CMD_SEND, 5'd1, 3'd0);
      send_item(sigpd_pkg::CMD_SEND, KILL_SIGNAL, 3'd0);
      send_item(sigpd_pkg::CMD_CHECK, 5'd0, 3'd0);         // 1 kills first
      send_item(sigpd_pkg::CMD_CHECK, 5'd0, 3'd0);         // then 9
      send_item(sigpd_pkg::CMD_CHECK, 5'd0, 3'd0);
      send_item(sigpd_pkg::CMD_SET, 5'd0, sigpd_pkg::ST_RUNNING);
      send_item(sigpd_pkg::CMD_SEND, 5'd15, 3'd0);
      send_item(sigpd_pkg::CMD_SEND, 5'd13, 3'd0);
      send_item(sigpd_pkg::CMD_CHECK, 5'd0, 3'd0);
      send_item(sigpd_pkg::CMD_SET, 5'd0, sigpd_pkg::ST_ZOMBIE);
      drain_results();
   endtask

   // All handled: every default kill is suppressed except the real kill.
   task automatic test_handled_mask();
      write_handled_mask(32'hFFFF_FFFF);
      send_item(sigpd_pkg::CMD_SET, 5'd0, sigpd_pkg::ST_READY);
      for (int n = 0; n < 32; n++)
         if (TERMINATING[n])
            send_item(sigpd_pkg::CMD_SEND, 5'(n), 3'd0);
      send_item(sigpd_pkg::CMD_SEND, KILL_SIGNAL, 3'd0);
      send_item(sigpd_pkg::CMD_SEND, 5'd20, 3'd0);
      send_item(sigpd_pkg::CMD_CHECK, 5'd0, 3'd0);
      send_item(sigpd_pkg::CMD_CHECK, 5'd0, 3'd0);
      drain_results();
   endtask

   function automatic logic [4:0] pick_signal();
      logic [4:0] notable[12] = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd8, 5'd9, 5'd11,
                                  5'd13, 5'd15, 5'd18, 5'd19};
      if ($urandom_range(0, 1) == 0)
         return notable[$urandom_range(0, 11)];
      return 5'($urandom_range(1, 31));
   endfunction

   task automatic run_random_items(int count);
      int         r;
      logic [1:0] cmd;
      logic [4:0] sig;
      logic [2:0] nst;
      repeat (count) begin
         r   = $urandom_range(0, 99);
         sig = 5'($urandom);
         nst = 3'($urandom);
         if (r < 45) begin
            cmd = sigpd_pkg::CMD_SEND;
            sig = pick_signal();
         end else if (r < 70) begin
            cmd = sigpd_pkg::CMD_CHECK;
         end else if (r < 88) begin
            cmd = sigpd_pkg::CMD_SET;
            nst = 3'($urandom_range(0, 4));
         end else if (r < 92) begin
            cmd = sigpd_pkg::CMD_SET;            // bad state value
            nst = 3'($urandom_range(5, 7));
         end else if (r < 96) begin
            cmd = sigpd_pkg::CMD_SEND;
            sig = 5'd0;
         end else begin
            cmd = CMD_UNUSED;
         end
         send_item(cmd, sig, nst);
      end
   endtask

   // Several handled-mask settings, one stretch without any idling.
   task automatic test_random_traffic();
      write_handled_mask(32'd0);
      run_random_items(100);
      drain_results();
      write_handled_mask(32'hFFFF_FFFF);
      quiet = 1'b1;
      run_random_items(90);
      drain_results();
      quiet = 1'b0;
      write_handled_mask($urandom);
      run_random_items(100);
      drain_results();
      write_handled_mask($urandom & TERMINATING);
      run_random_items(100);
      drain_results();
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_output_backpressure();
      write_handled_mask(32'h0000_2008);
      quiet = 1'b1;
      @(negedge clock);
      hold_off_cycles = 150;
      run_random_items(40);
      quiet = 1'b0;
      drain_results();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      shadow_pending = '0;
      shadow_state   = sigpd_pkg::ST_RUNNING;
      shadow_exit    = '0;
      shadow_handled = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_actions();
      test_handled_mask();
      test_random_traffic();
      test_output_backpressure();

      drain_results();
      if (mismatch_count == 0) begin
         $display("** signal_pending_delivery_top: PASSED **");
      end else begin
         $display("** signal_pending_delivery_top: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sigpd_pkg.sv
rtl/sigpd_csr.sv
rtl/sigpd_step.sv
rtl/signal_pending_delivery_top.sv
verif/tb.sv
